// File: rtl/core/i2c_register_file_slave_unit_macros.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef I2C_REGISTER_FILE_SLAVE_UNIT_MACROS_SVH
`define I2C_REGISTER_FILE_SLAVE_UNIT_MACROS_SVH

`define I2C_RF_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("violation");

`define I2C_RF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("violation");

`endif

// File: rtl/core/i2c_rf_pkg.sv
`timescale 1ns / 1ps
package i2c_rf_pkg;

  localparam int unsigned GROUP_BASE = 72;
  localparam int unsigned NUM_GROUPS = 4;
  localparam int unsigned GPIO_GROUP = 73;

  localparam bit GPIO_IN_RANGE = (GPIO_GROUP >= GROUP_BASE) &&
                                 (GPIO_GROUP < GROUP_BASE + NUM_GROUPS);
  localparam logic [1:0] GPIO_SEL = GPIO_IN_RANGE ? 2'(GPIO_GROUP - GROUP_BASE) : 2'd0;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned STORE_AW = 10;

  localparam logic [7:0] GPIO_IN_RESET = 8'd152;
  localparam logic [7:0] CARD_MASK_RESET = 8'd1;

  localparam int unsigned PADDR_W = 3;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SELECT = 3'd1,
    PH_WRITE1 = 3'd2,
    PH_WRITE2 = 3'd3,
    PH_READ1  = 3'd4
  } phase_e;

  typedef enum logic {
    REG_GPIO_IN   = 1'b0,
    REG_CARD_MASK = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] gpio_in_register;
    logic [7:0] card_detect_mask;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic [STORE_AW-1:0] raddr;
  } mem_req_t;

endpackage

// File: rtl/core/i2c_rf_cfg.sv
`timescale 1ns / 1ps
module i2c_rf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2c_rf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output i2c_rf_pkg::cfg_t             cfg_o
);
  import i2c_rf_pkg::*;

  logic [7:0] gpio_in_q, gpio_in_d;
  logic [7:0] mask_q, mask_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    gpio_in_d = gpio_in_q;
    mask_d    = mask_q;
    if (wr_en) begin
      case (idx)
        REG_GPIO_IN:   gpio_in_d = pwdata[7:0];
        REG_CARD_MASK: mask_d    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpio_in_q <= GPIO_IN_RESET;
      mask_q    <= CARD_MASK_RESET;
    end else begin
      gpio_in_q <= gpio_in_d;
      mask_q    <= mask_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (idx)
      REG_GPIO_IN:   prdata = {24'd0, gpio_in_q};
      REG_CARD_MASK: prdata = {24'd0, mask_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o.gpio_in_register = gpio_in_q;
  assign cfg_o.card_detect_mask = mask_q;
endmodule

// File: rtl/core/i2c_rf_mem.sv
`timescale 1ns / 1ps
module i2c_rf_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2c_rf_pkg::mem_req_t req_i,
  output logic [7:0]           rdata_o,
  output logic                 busy_o
);
  import i2c_rf_pkg::*;

  logic [7:0]          mem [STORE_DEPTH];
  logic [7:0]          rdata_q;
  logic                busy_q, busy_d;
  logic [STORE_AW-1:0] clr_q, clr_d;

  // clearing pass after reset
  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      clr_d = clr_q + STORE_AW'(1);
      if (clr_q == STORE_AW'(STORE_DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 8'd0;
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;
endmodule

// File: rtl/core/i2c_rf_ctrl.sv
`timescale 1ns / 1ps
module i2c_rf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2c_rf_pkg::cfg_t     cfg_i,
  input  logic                 busy_i,
  input  logic [7:0]           rdata_i,
  output i2c_rf_pkg::mem_req_t req_o,
  output logic                 adv_o,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tuser
);
  import i2c_rf_pkg::*;

  logic        in_v_q, in_v_d;
  op_e         op_q;
  logic [6:0]  addr_q;
  logic        rd_q;
  logic [7:0]  data_q;
  logic        present_q;

  phase_e      phase_q, phase_d;
  logic [1:0]  group_q, group_d;
  logic [7:0]  sel_q, sel_d;

  logic        m_v_q, m_v_d;
  logic [7:0]  rbyte_q, rbyte_d;
  logic        err_q, err_d;

  logic        adv, take;
  logic        we;
  logic [7:0]  addr_off;
  logic [7:0]  gpio_val;
  logic        gpio_hit;

  assign adv  = in_v_q && (!m_v_q || m_axis_tready);
  assign s_axis_tready = !busy_i && (!in_v_q || adv);
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_v_d = in_v_q;
    if (take) begin
      in_v_d = 1'b1;
    end else if (adv) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= op_e'(s_axis_tuser);
      addr_q    <= s_axis_tdata[6:0];
      rd_q      <= s_axis_tdata[7];
      data_q    <= s_axis_tdata[15:8];
      present_q <= s_axis_tdata[16];
    end
  end

  assign addr_off = {1'b0, addr_q} - 8'(GROUP_BASE);
  assign gpio_hit = GPIO_IN_RANGE && (group_q == GPIO_SEL) &&
                    (sel_q == cfg_i.gpio_in_register);

  always_comb begin
    gpio_val = rdata_i;
    if (gpio_hit) begin
      gpio_val = present_q ? (rdata_i & ~cfg_i.card_detect_mask)
                           : (rdata_i | cfg_i.card_detect_mask);
    end
  end

  always_comb begin
    phase_d = phase_q;
    group_d = group_q;
    sel_d   = sel_q;
    rbyte_d = 8'd0;
    err_d   = 1'b0;
    we      = 1'b0;
    if (adv) begin
      case (op_q)
        OP_START: begin
          if (phase_q == PH_WRITE1) begin
            phase_d = rd_q ? PH_READ1 : PH_WRITE2;
          end else if (phase_q == PH_IDLE && !rd_q) begin
            if ({1'b0, addr_q} >= 8'(GROUP_BASE) && addr_off < 8'(NUM_GROUPS)) begin
              group_d = addr_off[1:0];
              phase_d = PH_SELECT;
            end else begin
              err_d = 1'b1;
            end
          end else begin
            err_d = 1'b1;
          end
        end
        OP_STOP: phase_d = PH_IDLE;
        OP_READ: begin
          if (phase_q != PH_READ1) begin
            err_d = 1'b1;
          end else begin
            rbyte_d = gpio_val;
            sel_d   = sel_q + 8'd1;
          end
        end
        OP_WRITE: begin
          if (phase_q == PH_SELECT) begin
            sel_d   = data_q;
            phase_d = PH_WRITE1;
          end else if (phase_q == PH_WRITE1 || phase_q == PH_WRITE2) begin
            phase_d = PH_WRITE2;
            we      = 1'b1;
            sel_d   = sel_q + 8'd1;
          end else begin
            err_d = 1'b1;
          end
        end
        default: err_d = 1'b1;
      endcase
    end
  end

  always_comb begin
    m_v_d = m_v_q;
    if (adv) begin
      m_v_d = 1'b1;
    end else if (m_axis_tready) begin
      m_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      m_v_q   <= 1'b0;
      phase_q <= PH_IDLE;
      group_q <= 2'd0;
      sel_q   <= 8'd0;
    end else begin
      in_v_q  <= in_v_d;
      m_v_q   <= m_v_d;
      phase_q <= phase_d;
      group_q <= group_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rbyte_q <= rbyte_d;
      err_q   <= err_d;
    end
  end

  // read address follows the state the next request will see
  assign req_o.we    = we;
  assign req_o.waddr = {group_q, sel_q};
  assign req_o.wdata = data_q;
  assign req_o.raddr = {group_d, sel_d};

  assign adv_o         = adv;
  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = rbyte_q;
  assign m_axis_tuser  = err_q;
endmodule

// File: rtl/core/i2c_register_file_slave_unit.sv
// a request is held in the input register, then its result in the output register
// throughput: one request per cycle unless stalled; one store read and at most one
// store write each cycle; reset: asynchronous active low, then a clearing pass
// zeroes the 1024-byte store; no request is taken meanwhile (config writes are)
`timescale 1ns / 1ps
`include "i2c_register_file_slave_unit_macros.svh"
module i2c_register_file_slave_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2c_rf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // bus_address[6:0], is_read[7], data_byte[15:8], card_present[16], zero[23:17]
  input  logic [23:0]                    s_axis_tdata,
  // op[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // read_byte[7:0]
  output logic [7:0]                     m_axis_tdata,
  // error[0]
  output logic                           m_axis_tuser
);
  import i2c_rf_pkg::*;

  cfg_t       cfg;
  mem_req_t   req;
  logic [7:0] rdata;
  logic       busy;
  logic       adv;

  i2c_rf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2c_rf_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata),
    .busy_o  (busy)
  );

  i2c_rf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .busy_i        (busy),
    .rdata_i       (rdata),
    .req_o         (req),
    .adv_o         (adv),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  `I2C_RF_ASSERT_NEVER(a_no_take_while_clearing, busy && s_axis_tready)
  `I2C_RF_ASSERT_NEVER(a_no_write_while_clearing, busy && req.we)
  `I2C_RF_ASSERT_NEXT(a_adv_gives_result, adv, m_axis_tvalid)
  `I2C_RF_ASSERT_NEVER(a_error_zero_byte, m_axis_tvalid && m_axis_tuser && (m_axis_tdata != 8'd0))
endmodule

// File: tb/sv/i2c_register_file_slave_unit_tb.sv
`timescale 1ns / 1ps
module i2c_register_file_slave_unit_tb;
  import i2c_rf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned STALL_CYCLES = 400;

  typedef struct packed {
    logic [7:0] rdata;
    logic       err;
  } rsp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // bus_address[6:0], is_read[7], data_byte[15:8], card_present[16], zero[23:17]
  logic [23:0]         s_axis_tdata;
  // op[1:0]
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // read_byte[7:0]
  logic [7:0]          m_axis_tdata;
  // error[0]
  logic                m_axis_tuser;

  // predictor state
  phase_e              phase_q;
  logic [1:0]          group_q;
  logic [7:0]          reg_sel_q;
  logic [7:0]          reg_store_q [STORE_DEPTH];
  logic [7:0]          gpio_in_q;
  logic [7:0]          card_mask_q;

  rsp_t                pending_rsp_q [$];
  int unsigned         mismatch_count;
  int unsigned         items_sent;
  int unsigned         quiet_cycles;
  int unsigned         stall_req;
  int unsigned         hold_left;
  bit                  idling_on;

  i2c_register_file_slave_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic rsp_t predict_response(op_e op, logic [6:0] addr, logic rd,
                                            logic [7:0] data, logic present);
    rsp_t       rsp;
    int         ofs;
    logic [7:0] v;
    rsp = '0;
    case (op)
      OP_START: begin
        if (phase_q == PH_WRITE1) begin
          phase_q = rd ? PH_READ1 : PH_WRITE2;
        end else if (phase_q == PH_IDLE && !rd) begin
          ofs = int'(addr) - int'(GROUP_BASE);
          if (ofs >= 0 && ofs < int'(NUM_GROUPS)) begin
            group_q = 2'(ofs);
            phase_q = PH_SELECT;
          end else begin
            rsp.err = 1'b1;
          end
        end else begin
          rsp.err = 1'b1;
        end
      end
      OP_STOP: begin
        phase_q = PH_IDLE;
      end
      OP_READ: begin
        if (phase_q != PH_READ1) begin
          rsp.err = 1'b1;
        end else begin
          v = reg_store_q[{group_q, reg_sel_q}];
          // card-detect bits read clear while a card is present
          if (int'(group_q) + int'(GROUP_BASE) == int'(GPIO_GROUP) &&
              reg_sel_q == gpio_in_q) begin
            v = present ? (v & ~card_mask_q) : (v | card_mask_q);
          end
          rsp.rdata = v;
          reg_sel_q = reg_sel_q + 8'd1;
        end
      end
      default: begin
        if (phase_q == PH_SELECT) begin
          reg_sel_q = data;
          phase_q = PH_WRITE1;
        end else if (phase_q == PH_WRITE1 || phase_q == PH_WRITE2) begin
          phase_q = PH_WRITE2;
          reg_store_q[{group_q, reg_sel_q}] = data;
          reg_sel_q = reg_sel_q + 8'd1;
        end else begin
          rsp.err = 1'b1;
        end
      end
    endcase
    return rsp;
  endfunction

  task automatic send_request(input op_e op, input logic [6:0] addr, input logic rd,
                              input logic [7:0] data, input logic present);
    rsp_t rsp;
    @(negedge clk_i);
    if (idling_on) begin
      while ($urandom_range(0, 99) < 37) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, present, data, rd, addr};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    rsp = predict_response(op, addr, rd, data, present);
    pending_rsp_q.push_back(rsp);
    items_sent++;
  endtask

  task automatic send_start(input logic [6:0] addr, input logic rd);
    send_request(OP_START, addr, rd, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_write(input logic [7:0] data);
    send_request(OP_WRITE, 7'($urandom), 1'($urandom), data, 1'($urandom));
  endtask

  task automatic send_read(input logic present);
    send_request(OP_READ, 7'($urandom), 1'($urandom), 8'($urandom), present);
  endtask

  task automatic send_stop();
    send_request(OP_STOP, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_noise();
    send_request(op_e'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_register(input reg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == REG_GPIO_IN) begin
      gpio_in_q = value;
    end else begin
      card_mask_q = value;
    end
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== {24'd0, value}) begin
      report_mismatch("prdata", prdata, {24'd0, value});
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned nwr;
    logic [1:0]  grp;
    logic [6:0]  addr;
    logic [7:0]  sel;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        grp = ($urandom_range(0, 1) != 0) ? GPIO_SEL : 2'($urandom_range(0, 3));
        addr = (kind < 23) ? 7'($urandom_range(0, 127)) : 7'(int'(GROUP_BASE) + grp);
        send_start(addr, ($urandom_range(0, 99) < 5) ? 1'b1 : 1'b0);
        case ($urandom_range(0, 3))
          0: sel = gpio_in_q - 8'($urandom_range(0, 3));
          1: sel = 8'hfc + 8'($urandom_range(0, 3));
          default: sel = 8'($urandom);
        endcase
        send_write(sel);
        nwr = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
        repeat (nwr) send_write(8'($urandom));
        if ($urandom_range(0, 99) < 5) send_noise();
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          send_start(7'($urandom), 1'b1);
          repeat ($urandom_range(1, 6)) send_read(1'($urandom));
        end else if (kind < 70) begin
          send_start(7'($urandom), 1'b0);
          repeat ($urandom_range(1, 4)) send_write(8'($urandom));
        end
        if ($urandom_range(0, 99) < 90) send_stop();
      end
    end
  endtask

  task automatic test_protocol_errors();
    send_start(7'(GPIO_GROUP), 1'b1);
    send_read(1'b1);
    send_write(8'h00);
    send_start(7'(GROUP_BASE - 1), 1'b0);
    send_start(7'h7f, 1'b0);
    send_stop();
    send_start(7'(GROUP_BASE), 1'b0);
    send_start(7'(GROUP_BASE), 1'b0);
    send_write(8'hff);
    send_write(8'ha5);
    send_write(8'h5a);
    send_start(7'(GROUP_BASE), 1'b0);
    send_stop();
    send_start(7'(GROUP_BASE), 1'b0);
    send_write(8'hff);
    send_start(7'(GROUP_BASE), 1'b1);
    send_read(1'b0);
    send_read(1'b0);
    send_write(8'h11);
    send_start(7'(GROUP_BASE), 1'b0);
    send_stop();
    wait_drained();
  endtask

  task automatic test_card_detect();
    send_start(7'(GPIO_GROUP), 1'b0);
    send_write(gpio_in_q);
    send_start(7'(GPIO_GROUP), 1'b1);
    send_read(1'b1);
    send_stop();
    send_start(7'(GPIO_GROUP), 1'b0);
    send_write(gpio_in_q);
    send_start(7'(GPIO_GROUP), 1'b1);
    send_read(1'b0);
    send_stop();
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [7:0] gpio_set [5];
    logic [7:0] mask_set [5];
    gpio_set = '{GPIO_IN_RESET, 8'h00, 8'hff, 8'($urandom), 8'($urandom)};
    mask_set = '{CARD_MASK_RESET, 8'h00, 8'hff, 8'($urandom), 8'($urandom)};
    for (int i = 0; i < 5; i++) begin
      set_register(REG_GPIO_IN, gpio_set[i]);
      set_register(REG_CARD_MASK, mask_set[i]);
      run_random_traffic(280);
      wait_drained();
    end
  endtask

  task automatic test_no_idling();
    idling_on = 1'b0;
    run_random_traffic(200);
    wait_drained();
    idling_on = 1'b1;
  endtask

  task automatic test_output_stall();
    @(posedge clk_i);
    stall_req = STALL_CYCLES;
    run_random_traffic(200);
    wait_drained();
  endtask

  // response sink with random and long stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req != 0) begin
        hold_left = stall_req;
        stall_req = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !(idling_on && $urandom_range(0, 99) < 37);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && m_axis_tready && m_axis_tvalid !== 1'b0) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", {23'd0, m_axis_tuser, m_axis_tdata}, '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (m_axis_tdata !== want.rdata) begin
          report_mismatch("read_byte", 32'(m_axis_tdata), 32'(want.rdata));
        end
        if (m_axis_tuser !== want.err) begin
          report_mismatch("error", 32'(m_axis_tuser), 32'(want.err));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_STOP;
    rst_ni         = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    quiet_cycles   = 0;
    stall_req      = 0;
    hold_left      = 0;
    idling_on      = 1'b1;
    phase_q        = PH_IDLE;
    group_q        = '0;
    reg_sel_q      = '0;
    gpio_in_q      = GPIO_IN_RESET;
    card_mask_q    = CARD_MASK_RESET;
    foreach (reg_store_q[i]) reg_store_q[i] = 8'd0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_protocol_errors();
    test_card_detect();
    test_random_settings();
    test_no_idling();
    test_output_stall();

    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
